@@ rtl/core/plim_pkg.sv @@
// Shared types and constants for the priority level interrupt masker.
`timescale 1ns / 1ps
`default_nettype none

package plim_pkg;

  localparam int NUM_LEVELS = 8;
  localparam int LVL_W      = 3;
  localparam int LVL_IDX_W  = $clog2(NUM_LEVELS);
  localparam int LINES      = 64;
  localparam int WORD_BITS  = 32;
  localparam int POS_W      = 6;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 80;

  localparam logic [LVL_W-1:0] LVL_MAX        = LVL_W'(NUM_LEVELS - 1);
  localparam logic [LVL_W-1:0] DIS_LVL_RESET  = 3'd2;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_SET_LVL  = 2'd1;
  localparam logic [1:0] OP_EVENT    = 2'd2;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] RK_REG_ACK  = 2'd0;
  localparam logic [1:0] RK_LVL_SET  = 2'd1;
  localparam logic [1:0] RK_DISPATCH = 2'd2;
  localparam logic [1:0] RK_EMPTY    = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             nz;
  } scan_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/plim_scan.sv @@
// Bit walker that visits the dispatch word one position per cycle while ctrl.step is set.
`timescale 1ns / 1ps
`default_nettype none

module plim_scan
  import plim_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scan_ctrl_t       ctrl,
  input  wire logic [LINES-1:0] load_word,
  output scan_stat_t            stat
);

  logic [LINES-1:0] word_r, word_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos;
  logic [LINES-1:0] rest;

  // Visit order: primary word from bit 31 down, then extended word from bit 63 down.
  assign pos  = {cnt_r[POS_W-1], ~cnt_r[POS_W-2:0]};
  assign rest = word_r & ~(LINES'(1) << pos);

  assign stat.hit  = word_r[pos];
  assign stat.last = (rest == '0);
  assign stat.pos  = pos;
  assign stat.nz   = (word_r != '0);

  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    if (ctrl.load) begin
      word_nxt = load_word;
      cnt_nxt  = '0;
    end else if (ctrl.step) begin
      word_nxt = rest;
      cnt_nxt  = cnt_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      cnt_r  <= '0;
    end else begin
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/priority_level_interrupt_masker.sv @@
// Top level of the priority level interrupt masker.
//
// Usage: each input transaction carries an operation on in_tuser (register a
// line, set the priority level, or report an interrupt event) and its operands
// on in_tdata. Results leave on the output channel, the kind on out_tuser and
// tlast marking the final result of an operation. cfg_wr_en writes the level
// at or below which device interrupts stay off; write it only while idle.
// Timing: a register or set-level operation, or an event with nothing to
// dispatch, loads its single result into the output register from the execute
// state. Otherwise an event decides the masks in the execute state, then the
// bit walker visits one line position per cycle while the receiver does not
// stall, primary word from bit 31 down, then extended word from bit 63 down,
// and stops at the last set bit, whose result is the final one. The next
// transaction is accepted the cycle after the last result is loaded into the
// output register.
// Reset clears the level, the enable table, the masks and pending lines and
// sets the disabled level to 2. When the receiver stalls, the output register
// holds its result and the walker waits while the stall lasts.
`timescale 1ns / 1ps
`default_nettype none

module priority_level_interrupt_masker
  import plim_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: irq_number[5:0], new_level[8:6], lowering[9], event_lines[73:10],
  // level_lines[137:74], zero fill
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_tuser,   // opcode
  // out_tdata: duplicate_error[0], prior_level[3:1], fake_interrupt[4],
  // hardware_mask[68:5], dispatched_bit[74:69], has_handler[75], zero fill
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                 out_tuser,  // result_kind
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [LVL_W-1:0]      cfg_wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [LVL_W-1:0]  dis_lvl_r;
  logic [LVL_W-1:0]  cur_lvl_r, cur_lvl_nxt;
  logic [LINES-1:0]  tbl_r [NUM_LEVELS];
  logic [LINES-1:0]  tbl_nxt [NUM_LEVELS];
  logic [LINES-1:0]  reg_lines_r, reg_lines_nxt;
  logic [LINES-1:0]  desired_r, desired_nxt;
  logic [LINES-1:0]  hw_mask_r, hw_mask_nxt;
  logic [LINES-1:0]  pend_r, pend_nxt;

  // Latched operands of the transaction at work.
  logic [1:0]        op_r;
  logic [POS_W-1:0]  num_r;
  logic [LVL_W-1:0]  lvl_r;
  logic              low_r;
  logic [LINES-1:0]  ev_r;
  logic [LINES-1:0]  lv_r;
  logic [LVL_W-1:0]  lvl_in;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_last_r;

  logic              load_ok;
  logic              emit;
  logic [1:0]        e_kind;
  logic              e_dup;
  logic [LVL_W-1:0]  e_old;
  logic              e_fake;
  logic [POS_W-1:0]  e_bit;
  logic              e_hh;
  logic              e_last;

  scan_ctrl_t        sc_ctrl;
  scan_stat_t        sc_stat;
  logic [LINES-1:0]  sc_word;

  // Combinational helpers for the operation stage.
  logic [POS_W-1:0]  reg_pos;
  logic [LINES-1:0]  reg_bit;
  logic [LVL_W-1:0]  lvl_eff;
  logic [LINES-1:0]  des_sel;
  logic [LINES-1:0]  pend_tmp;
  logic [LINES-1:0]  irq_all;
  logic [LINES-1:0]  irq_m;

  assign in_tready  = (state_r == ST_IDLE);
  assign load_ok    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign lvl_in = (in_tdata[8:6] > LVL_MAX) ? LVL_MAX : in_tdata[8:6];

  // The line number is byte-reversed inside its 32-bit word.
  assign reg_pos = {num_r[5], ~num_r[4:3], num_r[2:0]};
  assign reg_bit = LINES'(1) << reg_pos;
  assign lvl_eff = (!low_r && (lvl_r > cur_lvl_r)) ? cur_lvl_r : lvl_r;
  assign des_sel = tbl_r[lvl_eff[LVL_IDX_W-1:0]];
  assign irq_all = ev_r | pend_r;

  always_comb begin
    state_nxt     = state_r;
    cur_lvl_nxt   = cur_lvl_r;
    reg_lines_nxt = reg_lines_r;
    desired_nxt   = desired_r;
    hw_mask_nxt   = hw_mask_r;
    pend_nxt      = pend_r;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      tbl_nxt[i] = tbl_r[i];
    end
    pend_tmp = pend_r;
    irq_m    = '0;
    sc_ctrl  = '0;
    sc_word  = '0;
    emit     = 1'b0;
    e_kind   = RK_REG_ACK;
    e_dup    = 1'b0;
    e_old    = '0;
    e_fake   = 1'b0;
    e_bit    = '0;
    e_hh     = 1'b0;
    e_last   = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (load_ok) begin
          case (op_r)
            OP_REGISTER: begin
              emit   = 1'b1;
              e_kind = RK_REG_ACK;
              if (reg_lines_r[reg_pos]) begin
                e_dup = 1'b1;
              end else begin
                reg_lines_nxt = reg_lines_r | reg_bit;
                for (int i = 0; i < NUM_LEVELS; i++) begin
                  if (i > int'(lvl_r)) begin
                    tbl_nxt[i] = tbl_r[i] | reg_bit;
                  end
                end
              end
              state_nxt = ST_IDLE;
            end
            OP_SET_LVL: begin
              emit        = 1'b1;
              e_kind      = RK_LVL_SET;
              e_old       = cur_lvl_r;
              cur_lvl_nxt = lvl_eff;
              if (lvl_eff > dis_lvl_r) begin
                desired_nxt = des_sel;
                if (cur_lvl_r < lvl_eff) begin
                  // Opening interrupts: restore the mask and latch asserted lines.
                  if ((hw_mask_r & des_sel) != des_sel) begin
                    hw_mask_nxt = des_sel;
                  end
                  pend_tmp = pend_r | lv_r;
                  pend_nxt = pend_tmp;
                  e_fake   = ((pend_tmp & des_sel) != '0);
                end
              end
              state_nxt = ST_IDLE;
            end
            OP_EVENT: begin
              // Unwanted events mask the controller lazily and stay pending.
              if ((ev_r & ~desired_r) != '0) begin
                hw_mask_nxt = desired_r;
                pend_tmp    = pend_r | irq_all;
              end
              irq_m    = irq_all & desired_r;
              pend_nxt = pend_tmp & ~irq_m;
              if (irq_m == '0) begin
                emit      = 1'b1;
                e_kind    = RK_EMPTY;
                state_nxt = ST_IDLE;
              end else begin
                sc_ctrl.load = 1'b1;
                sc_word      = irq_m;
                state_nxt    = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (load_ok) begin
          sc_ctrl.step = 1'b1;
          if (sc_stat.hit) begin
            emit   = 1'b1;
            e_kind = RK_DISPATCH;
            e_bit  = sc_stat.pos;
            e_hh   = reg_lines_r[sc_stat.pos];
            e_last = sc_stat.last;
            if (sc_stat.last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  plim_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (sc_ctrl),
    .load_word (sc_word),
    .stat      (sc_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dis_lvl_r   <= DIS_LVL_RESET;
      cur_lvl_r   <= '0;
      reg_lines_r <= '0;
      desired_r   <= '0;
      hw_mask_r   <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        tbl_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_lvl_r   <= cur_lvl_nxt;
      reg_lines_r <= reg_lines_nxt;
      desired_r   <= desired_nxt;
      hw_mask_r   <= hw_mask_nxt;
      pend_r      <= pend_nxt;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        tbl_r[i] <= tbl_nxt[i];
      end
      if (cfg_wr_en) begin
        dis_lvl_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      num_r <= in_tdata[5:0];
      lvl_r <= lvl_in;
      low_r <= in_tdata[9];
      ev_r  <= in_tdata[73:10];
      lv_r  <= in_tdata[137:74];
    end
    if (emit) begin
      out_kind_r <= e_kind;
      out_last_r <= e_last;
      out_data_r <= {4'd0, e_hh, e_bit, hw_mask_nxt, e_fake, e_old, e_dup};
    end
  end

  // The walker only runs while some enabled line is still to be dispatched.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> sc_stat.nz)
    else $error("walker running on an empty word");

  // Register, level and empty results are always single transactions.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RK_REG_ACK || out_tuser == RK_LVL_SET || out_tuser == RK_EMPTY)
      |-> out_tlast)
    else $error("single result without tlast");

  // The current level never leaves the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    cur_lvl_r <= LVL_MAX)
    else $error("current level beyond the table");

  // A result never loads over a result still waiting for the receiver.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !emit)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
